>>> rtl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants and types of the PI regulator with output clamp.
// ----------------------------------------------------------------------------
package pca_pkg;

    // Gain registers are unsigned with a fixed width.
    localparam int GAIN_W = 31;

    // Register index port.
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_T    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 2'd3;

    // Gain reset values have 16 fraction bits, the limit is an integer; all are rescaled at elaboration.
    localparam longint KP_RST_Q16    = 64'sd18350;
    localparam longint KI_T_RST_Q16  = 64'sd3041;
    localparam longint OUT_LIMIT_INT = 64'sd100;
    localparam int     RST_FRAC      = 16;

    // Queue occupancy flags handed to the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

>>> rtl/pca_fifo.sv
// ----------------------------------------------------------------------------
// pca_fifo
// Short register queue between the front and back parts of the regulator.
// ----------------------------------------------------------------------------
module pca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output pca_pkg::fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/pca_front.sv
// ----------------------------------------------------------------------------
// pca_front
// Accepts samples and forms the error, both gain products and the terms
// that do not depend on the integrator, then pushes them to the queue.
// ----------------------------------------------------------------------------
module pca_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [DATA_WIDTH-1:0]             setpoint,
    input  logic [DATA_WIDTH-1:0]             measured,
    input  logic [pca_pkg::GAIN_W-1:0]        kp,
    input  logic [pca_pkg::GAIN_W-1:0]        ki_t,
    input  logic [DATA_WIDTH-1:0]             out_max,
    input  logic [DATA_WIDTH-1:0]             out_min,
    input  pca_pkg::fifo_stat_t               stat,
    output logic                              push,
    output logic [2*(pca_pkg::GAIN_W+DATA_WIDTH+1)+2*DATA_WIDTH:0] push_data
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = pca_pkg::GAIN_W + DW + 1;
    localparam int SW = PW + 1;

    function automatic logic [DW-1:0] sat_dw(input logic [SW-1:0] x);
        logic [SW-DW:0] top;
        top = x[SW-1:DW-1];
        if (&top || ~|top)
        begin
            return x[DW-1:0];
        end
        else
        begin
            return x[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [DW:0]          diff;
    logic [DW-1:0]        err_next;
    logic signed [DW-1:0] err_reg;
    logic signed [PW-1:0] prod_p_reg, prod_i_reg;
    logic signed [PW-1:0] p_term, i_term;
    logic [SW-1:0]        s_next, s_reg;
    logic [PW-1:0]        i_reg;
    logic [DW-1:0]        hi_next, hi_reg, lo_next, lo_reg;

    // The whole front pipeline holds while its last stage waits on a full queue.
    assign en       = !v3_reg || !stat.full;
    assign in_ready = en;
    assign push     = v3_reg;
    assign push_data = {s_reg, i_reg, hi_reg, lo_reg};

    assign diff     = {setpoint[DW-1], setpoint} - {measured[DW-1], measured};
    assign err_next = (diff[DW] != diff[DW-1])
                    ? (diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                    : diff[DW-1:0];

    // Arithmetic shift gives the floor of the scaled product.
    assign p_term  = prod_p_reg >>> FRAC_BITS;
    assign i_term  = prod_i_reg >>> FRAC_BITS;
    assign s_next  = SW'(p_term) + SW'(i_term);
    assign hi_next = sat_dw(SW'($signed(out_max)) - SW'(p_term));
    assign lo_next = sat_dw(SW'($signed(out_min)) - SW'(p_term));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg    <= err_next;
            prod_p_reg <= PW'($signed({1'b0, kp})) * PW'(err_reg);
            prod_i_reg <= PW'($signed({1'b0, ki_t})) * PW'(err_reg);
            s_reg      <= s_next;
            i_reg      <= i_term;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

endmodule

>>> rtl/pca_back.sv
// ----------------------------------------------------------------------------
// pca_back
// Closes the integrator loop: sums, clamps, updates the integrator with
// back-calculation and holds the result in the output register.
// ----------------------------------------------------------------------------
module pca_back #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pca_pkg::fifo_stat_t   stat,
    output logic                  pop,
    input  logic [2*(pca_pkg::GAIN_W+DATA_WIDTH+1)+2*DATA_WIDTH:0] pop_data,
    input  logic [DATA_WIDTH-1:0] out_max,
    input  logic [DATA_WIDTH-1:0] out_min,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] drive
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = pca_pkg::GAIN_W + DW + 1;
    localparam int SW  = PW + 1;
    localparam int TW  = SW + 1;

    function automatic logic [DW-1:0] sat_dw(input logic [TW-1:0] x);
        logic [TW-DW:0] top;
        top = x[TW-1:DW-1];
        if (&top || ~|top)
        begin
            return x[DW-1:0];
        end
        else
        begin
            return x[TW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    logic [SW-1:0]        s_in;
    logic [PW-1:0]        i_in;
    logic [DW-1:0]        hi_in, lo_in;
    logic signed [TW-1:0] sum;
    logic [TW-1:0]        mid;
    logic [DW-1:0]        integ_reg, integ_next;
    logic [DW-1:0]        drive_reg, drive_next;
    logic                 out_valid_reg;
    logic                 fire;

    assign {s_in, i_in, hi_in, lo_in} = pop_data;

    assign pop       = !out_valid_reg || out_ready;
    assign fire      = pop && !stat.empty;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    assign sum = TW'($signed(s_in)) + TW'($signed(integ_reg));
    assign mid = TW'($signed(i_in)) + TW'($signed(integ_reg));

    // The upper limit wins when the limits cross.
    always_comb
    begin
        priority if (sum >= TW'($signed(out_max)))
        begin
            drive_next = out_max;
            integ_next = hi_in;
        end
        else if (sum < TW'($signed(out_min)))
        begin
            drive_next = out_min;
            integ_next = lo_in;
        end
        else
        begin
            drive_next = sum[DW-1:0];
            integ_next = sat_dw(mid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                integ_reg <= integ_next;
            end
            if (pop)
            begin
                out_valid_reg <= !stat.empty;
            end
        end
    end

endmodule

>>> rtl/pi_controller_antiwindup_top.sv
// ----------------------------------------------------------------------------
// pi_controller_antiwindup_top
// PI regulator with output clamp and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Usage: each item on the slave stream carries a setpoint and a measured
// value in signed fixed point. For each item one clamped drive value leaves
// on the master stream, in order. Gains and clamp limits are written through
// the cfg port (kp, ki_t, out_max, out_min) by the user only while the block
// is idle; the block itself does not enforce this. Throughput is one item
// per cycle while the receiver does not stall. Each item passes, in order,
// through the error register, the gain multipliers, the term preparation
// stage, the queue and the output register loaded by the integrator update.
// The integrator add and clamp are combinational; the write-back lands in
// the same cycle as the output register load. Reset clears the integrator,
// empties the pipeline and queue and loads the default gains and limits.
// When the receiver stalls, the output register holds its item, the back
// part stops, and the four-entry queue absorbs the front; s_axis_tready
// drops once the queue is full while the last front stage holds an item.
// ----------------------------------------------------------------------------
module pi_controller_antiwindup_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    // setpoint [DATA_WIDTH-1:0], measured [2*DATA_WIDTH-1:DATA_WIDTH]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // drive [DATA_WIDTH-1:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [((DATA_WIDTH > pca_pkg::GAIN_W) ? DATA_WIDTH : pca_pkg::GAIN_W)-1:0] cfg_data
);

    localparam int DW      = DATA_WIDTH;
    localparam int GW      = pca_pkg::GAIN_W;
    localparam int OUT_W   = ((DW + 7) / 8) * 8;
    localparam int PW      = GW + DW + 1;
    localparam int QW      = 2 * PW + 2 * DW + 1;
    localparam int Q_DEPTH = 4;

    localparam logic [GW-1:0] KP_RST = (FRAC_BITS >= pca_pkg::RST_FRAC)
        ? GW'(pca_pkg::KP_RST_Q16 << (FRAC_BITS - pca_pkg::RST_FRAC))
        : GW'(pca_pkg::KP_RST_Q16 >> (pca_pkg::RST_FRAC - FRAC_BITS));
    localparam logic [GW-1:0] KI_T_RST = (FRAC_BITS >= pca_pkg::RST_FRAC)
        ? GW'(pca_pkg::KI_T_RST_Q16 << (FRAC_BITS - pca_pkg::RST_FRAC))
        : GW'(pca_pkg::KI_T_RST_Q16 >> (pca_pkg::RST_FRAC - FRAC_BITS));
    localparam logic [DW-1:0] OUT_MAX_RST = DW'(pca_pkg::OUT_LIMIT_INT << FRAC_BITS);
    localparam logic [DW-1:0] OUT_MIN_RST = DW'(-(pca_pkg::OUT_LIMIT_INT << FRAC_BITS));

    logic [GW-1:0]       kp_reg, ki_t_reg;
    logic [DW-1:0]       out_max_reg, out_min_reg;
    pca_pkg::fifo_stat_t stat;
    logic                push, pop;
    logic [QW-1:0]       push_data, pop_data;
    logic [DW-1:0]       drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= KP_RST;
            ki_t_reg    <= KI_T_RST;
            out_max_reg <= OUT_MAX_RST;
            out_min_reg <= OUT_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pca_pkg::REG_KP:      kp_reg      <= cfg_data[GW-1:0];
                pca_pkg::REG_KI_T:    ki_t_reg    <= cfg_data[GW-1:0];
                pca_pkg::REG_OUT_MAX: out_max_reg <= cfg_data[DW-1:0];
                pca_pkg::REG_OUT_MIN: out_min_reg <= cfg_data[DW-1:0];
                default:              ;
            endcase
        end
    end

    pca_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .setpoint  (s_axis_tdata[DW-1:0]),
        .measured  (s_axis_tdata[2*DW-1:DW]),
        .kp        (kp_reg),
        .ki_t      (ki_t_reg),
        .out_max   (out_max_reg),
        .out_min   (out_min_reg),
        .stat      (stat),
        .push      (push),
        .push_data (push_data)
    );

    pca_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    pca_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop       (pop),
        .pop_data  (pop_data),
        .out_max   (out_max_reg),
        .out_min   (out_min_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .drive     (drive)
    );

    assign m_axis_tdata = OUT_W'(drive);

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PI regulator with clamp and anti-windup.
// A queue of setpoint/measured items feeds a stream driver. A clocked monitor
// keeps its own fixed-point copy of the regulator: gains, limits and the
// integrator. It predicts each drive value when an item is accepted and
// compares it with the result stream in order. Gains and limits change
// between phases, while the pipeline is empty, from defaults to extremes
// and then to random settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  FRAC        = 16;
    localparam int  CYCLE_LIMIT = 150000;
    localparam int  SOAK_PHASES = 8;
    localparam int  SOAK_ITEMS  = 155;

    localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [pca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Setpoint in the low word, measured value in the high word.
    logic [63:0]        stim_pending[$];
    logic signed [31:0] drive_expect[$];

    // Regulator copy; starts at the reset settings.
    logic [30:0]        kp_gain    = 31'd18350;
    logic [30:0]        ki_gain    = 31'd3041;
    logic signed [31:0] lim_hi     = 32'sd6553600;
    logic signed [31:0] lim_lo     = -32'sd6553600;
    logic signed [31:0] integ_acc  = '0;

    logic        steady = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;

    pi_controller_antiwindup_top #(
        .DATA_WIDTH (32),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic signed [31:0] sat_word(longint v);
        if (v > longint'(32'sh7fff_ffff))
            return 32'sh7fff_ffff;
        if (v < -longint'(64'sh8000_0000))
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] any_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1:
            begin
                case ($urandom_range(4))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = 32'h0;
                    3: v = 32'hffff_ffff;
                    default: v = 32'h1;
                endcase
            end
            2: v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
            default: v = $urandom_range(32'h0002_0000) - 32'h0001_0000;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     what, $signed(want), want, $signed(got), got);
    endtask

    // ------------------------------------------------------------------------
    // Driver: a new item is presented only once the current one is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (stim_pending.size() > 0 && (steady || $urandom_range(99) >= 13))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stim_pending.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(99) >= 13);
    end

    // ------------------------------------------------------------------------
    // Monitor: register writes, prediction on input accept, check on output.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic signed [31:0] sp, mv, want;
        longint err, pterm, iterm, sum, y;
        if (!rst_n)
        begin
            kp_gain   = 31'd18350;
            ki_gain   = 31'd3041;
            lim_hi    = 32'sd6553600;
            lim_lo    = -32'sd6553600;
            integ_acc = '0;
            drive_expect.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pca_pkg::REG_KP:      kp_gain = cfg_data[30:0];
                    pca_pkg::REG_KI_T:    ki_gain = cfg_data[30:0];
                    pca_pkg::REG_OUT_MAX: lim_hi  = cfg_data;
                    pca_pkg::REG_OUT_MIN: lim_lo  = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sp    = s_axis_tdata[31:0];
                mv    = s_axis_tdata[63:32];
                err   = sat_word(longint'(sp) - longint'(mv));
                // Arithmetic shift of the signed product rounds toward minus infinity.
                pterm = (longint'(kp_gain) * err) >>> FRAC;
                iterm = (longint'(ki_gain) * err) >>> FRAC;
                sum   = pterm + iterm + longint'(integ_acc);
                // The upper limit is tested first, so it wins when the limits cross.
                if (sum >= longint'(lim_hi))
                    y = lim_hi;
                else if (sum < longint'(lim_lo))
                    y = lim_lo;
                else
                    y = sum;
                integ_acc = sat_word(y - pterm);
                drive_expect.push_back(y[31:0]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_expect.size() == 0)
                begin
                    report_mismatch("unexpected drive", 32'h0, m_axis_tdata);
                end
                else
                begin
                    want = drive_expect.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("drive", want, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        @(negedge clk);
        while (stim_pending.size() > 0 || s_axis_tvalid || drive_expect.size() > 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_regs(logic [30:0] kp, logic [30:0] ki,
                                logic [31:0] hi, logic [31:0] lo);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= pca_pkg::REG_KP;
        cfg_data  <= {1'b0, kp};
        @(posedge clk);
        cfg_index <= pca_pkg::REG_KI_T;
        cfg_data  <= {1'b0, ki};
        @(posedge clk);
        cfg_index <= pca_pkg::REG_OUT_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= pca_pkg::REG_OUT_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_corners();
        stim_pending.push_back({WORD_MIN, WORD_MAX});
        stim_pending.push_back({WORD_MAX, WORD_MIN});
        stim_pending.push_back({32'h0, 32'h0});
        stim_pending.push_back({WORD_MAX, WORD_MAX});
        stim_pending.push_back({WORD_MIN, WORD_MIN});
        stim_pending.push_back({32'h1, 32'h0});
        stim_pending.push_back({32'h0, 32'h1});
        stim_pending.push_back({32'hffff_ffff, 32'h0});
        stim_pending.push_back({32'h0, 32'h0001_0000});
        stim_pending.push_back({32'hffff_0000, 32'h0});
        stim_pending.push_back({32'h0, 32'h0640_0000});
        stim_pending.push_back({32'h0640_0000, 32'h0});
    endtask

    task automatic push_random(int count);
        logic [31:0] sp, mv;
        for (int i = 0; i < count; i++)
        begin
            // Mostly a loop near its setpoint; the rest are arbitrary pairs.
            if ($urandom_range(99) < 60)
            begin
                sp = $urandom_range(32'h0200_0000) - 32'h0100_0000;
                mv = sp + ($urandom_range(32'h0002_0000) - 32'h0001_0000);
            end
            else
            begin
                sp = any_value();
                mv = any_value();
            end
            stim_pending.push_back({mv, sp});
        end
    endtask

    initial
    begin
        logic [30:0] kp, ki;
        logic [31:0] a, b;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings.
        push_corners();
        wait_idle();

        // Largest gains and the widest output range.
        program_regs(31'h7fff_ffff, 31'h7fff_ffff, WORD_MAX, WORD_MIN);
        push_corners();
        wait_idle();

        // Zero gains with both limits at zero.
        program_regs(31'h0, 31'h0, 32'h0, 32'h0);
        push_random(60);
        wait_idle();

        // Crossed limits: the lower bound sits above the upper one.
        program_regs(31'd65536, 31'd2000, 32'hfffc_0000, 32'h0004_0000);
        push_random(80);
        wait_idle();

        for (int ph = 0; ph < SOAK_PHASES; ph++)
        begin
            kp = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(32'h0010_0000));
            ki = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(32'h0000_4000));
            a  = any_value();
            b  = any_value();
            if ($urandom_range(7) != 0 && $signed(a) < $signed(b))
                program_regs(kp, ki, b, a);
            else
                program_regs(kp, ki, a, b);
            if (ph == 3)
                steady <= 1'b1;
            push_random(SOAK_ITEMS);
            wait_idle();
            steady <= 1'b0;
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
